// File: rtl/core/nas_pkg.sv
// Package with the shared constants and fixed-point helpers of the normal axis admittance step.
package nas_pkg;

	localparam int unsigned CFG_W = 31;
	localparam int unsigned IDX_W = 3;
	localparam int unsigned PROD_W = 66;
	localparam int unsigned OPND_W = 33;
	localparam int unsigned DVD_W = 58;
	localparam int unsigned CNT_W = 6;

	localparam logic [IDX_W-1:0] REG_MASS = 3'd0;
	localparam logic [IDX_W-1:0] REG_DAMP = 3'd1;
	localparam logic [IDX_W-1:0] REG_STIFF = 3'd2;
	localparam logic [IDX_W-1:0] REG_LEAK = 3'd3;
	localparam logic [IDX_W-1:0] REG_ILIM = 3'd4;
	localparam logic [IDX_W-1:0] REG_STEP = 3'd5;
	localparam logic [IDX_W-1:0] REG_VLIM = 3'd6;
	localparam logic [IDX_W-1:0] REG_DLIM = 3'd7;

	localparam logic OP_STEP = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [30:0] MASS_MIN = 31'd3277;
	localparam logic [16:0] LEAK_ONE = 17'd65536;
	localparam logic [30:0] ILIM_MIN = 31'd6554;
	localparam logic [30:0] LIMIT_MIN = 31'd2684;

	localparam logic [30:0] ACC_MAX = 31'd16777;
	localparam logic [31:0] DEADBAND = 32'd0;

	localparam logic [30:0] RST_MASS = 31'd65536;
	localparam logic [30:0] RST_ILIM = 31'd655360;
	localparam logic [30:0] RST_STEP = 31'd268435;
	localparam logic [30:0] RST_VLIM = 31'd2684355;

	typedef logic signed [PROD_W-1:0] wide_t;

	function automatic wide_t round_shift(input wide_t v, input int unsigned n);
		wide_t half;
		half = wide_t'(1) <<< (n - 1);
		return (v + half) >>> n;
	endfunction

	function automatic logic [31:0] sat32(input wide_t v);
		if (v > wide_t'(32'sh7fffffff)) begin
			return 32'h7fffffff;
		end
		if (v < -wide_t'(33'sh080000000)) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] clamp_mag(input wide_t v, input logic [30:0] lim);
		wide_t l;
		l = wide_t'({1'b0, lim});
		if (v > l) begin
			return {1'b0, lim};
		end
		if (v < -l) begin
			return 32'(-l);
		end
		return v[31:0];
	endfunction

	function automatic wide_t sx32(input logic [31:0] v);
		return wide_t'({{(PROD_W-32){v[31]}}, v});
	endfunction

endpackage

// File: rtl/core/nas_mul.sv
// Shared registered signed multiplier of the admittance step.
module nas_mul (
	input  logic                                     clk,
	input  logic signed [nas_pkg::OPND_W-1:0]        a,
	input  logic signed [nas_pkg::OPND_W-1:0]        b,
	output logic signed [nas_pkg::PROD_W-1:0]        prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// File: rtl/core/nas_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module nas_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nas_pkg::DVD_W-1:0]     dividend,
	input  logic [30:0]                   divisor,
	output logic                          done_q,
	output logic [nas_pkg::DVD_W-1:0]     quo_q
);

	logic [30:0] rem_q;
	logic [30:0] dsr_q;
	logic [nas_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [32:0] trial;

	assign trial = {1'b0, rem_q, quo_q[nas_pkg::DVD_W-1]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= nas_pkg::CNT_W'(nas_pkg::DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[30:0];
			end else begin
				rem_q <= {rem_q[29:0], quo_q[nas_pkg::DVD_W-1]};
			end
			quo_q <= {quo_q[nas_pkg::DVD_W-2:0], ~trial[32]};
		end
	end

endmodule

// File: rtl/core/normal_axis_admittance_step.sv
// Top level of the normal axis admittance step: sequencer, state and output word register.
//
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_stall   operation, force_target, force_measured, time_step
// out      output     out_valid / out_stall delta_normal ... saturated
//
// A control step runs the multiplier passes and the divide start, the 58-bit acceleration
// divide, two more multiplier passes and the output load; six passes share one multiplier.
// The next word can be accepted once the step has returned to idle.
// A clear or a zero time step goes straight to the output load.
// Reset zeroes the state and loads the register defaults.
// The output word waits in its register while out_stall is high; in_stall is high from
// acceptance until the result is loaded into the output register.
module normal_axis_admittance_step #(
	parameter logic [30:0] ACC_MAX = nas_pkg::ACC_MAX,
	parameter logic [31:0] DEADBAND = nas_pkg::DEADBAND
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic signed [31:0]  force_target,
	input  logic signed [31:0]  force_measured,
	input  logic [23:0]         time_step,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  delta_normal,
	output logic signed [31:0]  position,
	output logic signed [31:0]  velocity,
	output logic signed [31:0]  acceleration,
	output logic signed [31:0]  integral,
	output logic signed [31:0]  contact_error,
	output logic signed [31:0]  damping_force,
	output logic signed [31:0]  spring_force,
	output logic                saturated,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [30:0]         cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M1 = 4'd1;
	localparam logic [3:0] ST_M2 = 4'd2;
	localparam logic [3:0] ST_M3 = 4'd3;
	localparam logic [3:0] ST_M4 = 4'd4;
	localparam logic [3:0] ST_M5 = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_M6 = 4'd7;
	localparam logic [3:0] ST_M7 = 4'd8;
	localparam logic [3:0] ST_M8 = 4'd9;
	localparam logic [3:0] ST_M9 = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0] state_q;
	logic [30:0] mass_q, damp_cfg_q, stiff_q, ilim_q, step_q, vlim_q, dlim_q;
	logic [16:0] leak_q;
	logic [30:0] mass_eff, ilim_eff, slim_eff, vlim_eff, dlim_eff;
	logic [16:0] leak_eff, leak_comp;

	logic [31:0] int_q, vel_q, pos_q, acc_q, cmd_q, err_q, dampf_q, spring_q;
	logic sat_q;
	logic [23:0] dt_q;
	logic signed [32:0] i1_q;
	logic num_neg_q;

	logic signed [32:0] diff;
	logic [31:0] err_sat, err_db;
	logic [32:0] err_abs;

	logic signed [nas_pkg::OPND_W-1:0] mul_a, mul_b;
	nas_pkg::wide_t prod_q;
	nas_pkg::wide_t integ_sum, num, vel_sum, pos_sum, cmd_w;
	logic [31:0] spring_new, cmd_new;
	logic [33:0] num_mag;
	logic [33:0] pos_abs, cmd_abs;

	logic div_start, div_done;
	logic [nas_pkg::DVD_W-1:0] div_quo;
	logic [31:0] acc_mag;

	logic accept, out_free;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	assign mass_eff = (mass_q < nas_pkg::MASS_MIN) ? nas_pkg::MASS_MIN : mass_q;
	assign leak_eff = (leak_q > nas_pkg::LEAK_ONE) ? nas_pkg::LEAK_ONE : leak_q;
	assign leak_comp = nas_pkg::LEAK_ONE - leak_eff;
	assign ilim_eff = (ilim_q < nas_pkg::ILIM_MIN) ? nas_pkg::ILIM_MIN : ilim_q;
	assign slim_eff = (step_q < nas_pkg::LIMIT_MIN) ? nas_pkg::LIMIT_MIN : step_q;
	assign vlim_eff = (vlim_q < nas_pkg::LIMIT_MIN) ? nas_pkg::LIMIT_MIN : vlim_q;
	assign dlim_eff = (dlim_q < slim_eff) ? slim_eff : dlim_q;

	assign diff = {force_target[31], force_target} - {force_measured[31], force_measured};
	assign err_sat = nas_pkg::sat32(nas_pkg::wide_t'(diff));
	assign err_abs = err_sat[31] ? (33'd0 - {1'b1, err_sat}) : {1'b0, err_sat};
	assign err_db = (err_abs < {1'b0, DEADBAND}) ? 32'd0 : err_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= nas_pkg::RST_MASS;
			damp_cfg_q <= '0;
			stiff_q <= '0;
			leak_q <= '0;
			ilim_q <= nas_pkg::RST_ILIM;
			step_q <= nas_pkg::RST_STEP;
			vlim_q <= nas_pkg::RST_VLIM;
			dlim_q <= nas_pkg::RST_VLIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nas_pkg::REG_MASS: mass_q <= cfg_data;
				nas_pkg::REG_DAMP: damp_cfg_q <= cfg_data;
				nas_pkg::REG_STIFF: stiff_q <= cfg_data;
				nas_pkg::REG_LEAK: leak_q <= cfg_data[16:0];
				nas_pkg::REG_ILIM: ilim_q <= cfg_data;
				nas_pkg::REG_STEP: step_q <= cfg_data;
				nas_pkg::REG_VLIM: vlim_q <= cfg_data;
				nas_pkg::REG_DLIM: dlim_q <= cfg_data;
				default: mass_q <= mass_q;
			endcase
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_M1: begin
				mul_a = {16'd0, leak_comp};
				mul_b = {int_q[31], int_q};
			end
			ST_M2: begin
				mul_a = {err_q[31], err_q};
				mul_b = {9'd0, dt_q};
			end
			ST_M3: begin
				mul_a = {2'b00, damp_cfg_q};
				mul_b = {vel_q[31], vel_q};
			end
			ST_M4: begin
				mul_a = {2'b00, stiff_q};
				mul_b = {pos_q[31], pos_q};
			end
			ST_M6: begin
				mul_a = {acc_q[31], acc_q};
				mul_b = {9'd0, dt_q};
			end
			ST_M8: begin
				mul_a = {vel_q[31], vel_q};
				mul_b = {9'd0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	nas_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign integ_sum = nas_pkg::wide_t'(i1_q) + nas_pkg::round_shift(prod_q, 24);
	assign spring_new = nas_pkg::sat32(nas_pkg::round_shift(prod_q, 28));
	assign num = nas_pkg::sx32(err_q) + nas_pkg::sx32(int_q) - nas_pkg::sx32(dampf_q)
		- nas_pkg::sx32(spring_new);
	assign num_mag = num[nas_pkg::PROD_W-1] ? 34'(-num) : num[33:0];
	assign div_start = (state_q == ST_M5);

	nas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({num_mag, 24'd0}),
		.divisor  (mass_eff),
		.done_q   (div_done),
		.quo_q    (div_quo)
	);

	assign acc_mag = (div_quo > nas_pkg::DVD_W'(ACC_MAX)) ?
		{1'b0, ACC_MAX} : div_quo[31:0];

	assign vel_sum = nas_pkg::sx32(vel_q) + nas_pkg::round_shift(prod_q, 20);
	assign cmd_new = nas_pkg::clamp_mag(nas_pkg::round_shift(prod_q, 24), slim_eff);
	assign cmd_w = nas_pkg::sx32(cmd_new);
	assign pos_sum = nas_pkg::sx32(pos_q) + cmd_w;
	assign pos_abs = pos_sum[nas_pkg::PROD_W-1] ? 34'(-pos_sum) : pos_sum[33:0];
	assign cmd_abs = cmd_w[nas_pkg::PROD_W-1] ? 34'(-cmd_w) : cmd_w[33:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			int_q <= '0;
			vel_q <= '0;
			pos_q <= '0;
			acc_q <= '0;
			cmd_q <= '0;
			err_q <= '0;
			dampf_q <= '0;
			spring_q <= '0;
			sat_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == nas_pkg::OP_CLEAR) begin
							int_q <= '0;
							vel_q <= '0;
							pos_q <= '0;
							acc_q <= '0;
							cmd_q <= '0;
							err_q <= '0;
							dampf_q <= '0;
							spring_q <= '0;
							sat_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (time_step == 24'd0) begin
							state_q <= ST_DONE;
						end else begin
							err_q <= err_db;
							state_q <= ST_M1;
						end
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: begin
					int_q <= nas_pkg::clamp_mag(integ_sum, ilim_eff);
					state_q <= ST_M4;
				end
				ST_M4: begin
					dampf_q <= nas_pkg::sat32(nas_pkg::round_shift(prod_q, 28));
					state_q <= ST_M5;
				end
				ST_M5: begin
					spring_q <= spring_new;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						acc_q <= num_neg_q ? (32'd0 - acc_mag) : acc_mag;
						state_q <= ST_M6;
					end
				end
				ST_M6: state_q <= ST_M7;
				ST_M7: begin
					vel_q <= nas_pkg::clamp_mag(vel_sum, vlim_eff);
					state_q <= ST_M8;
				end
				ST_M8: state_q <= ST_M9;
				ST_M9: begin
					cmd_q <= cmd_new;
					sat_q <= (pos_abs >= {3'd0, dlim_eff}) || (cmd_abs >= {3'd0, slim_eff});
					pos_q <= nas_pkg::clamp_mag(pos_sum, dlim_eff);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q <= time_step;
		end
		if (state_q == ST_M2) begin
			i1_q <= 33'(nas_pkg::round_shift(prod_q, 16));
		end
		if (state_q == ST_M5) begin
			num_neg_q <= num[nas_pkg::PROD_W-1];
		end
		if (state_q == ST_DONE && out_free) begin
			delta_normal <= cmd_q;
			position <= pos_q;
			velocity <= vel_q;
			acceleration <= acc_q;
			integral <= int_q;
			contact_error <= err_q;
			damping_force <= dampf_q;
			spring_force <= spring_q;
			saturated <= sat_q;
		end
	end

`ifndef SYNTH
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("output word raised outside the done step");
	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(delta_normal))
		else $error("stalled output word changed");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input taken while a step is in progress");
`endif

endmodule

// File: dv/normal_axis_admittance_step_tb.sv
// Testbench for the normal axis admittance step: random and directed words against a predictor.
`timescale 1ns / 100ps

module normal_axis_admittance_step_tb;

	typedef struct packed {
		logic        op;
		logic [31:0] ft;
		logic [31:0] fm;
		logic [23:0] dt;
	} step_word_t;

	typedef struct packed {
		logic [31:0] delta;
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
		logic [31:0] integ;
		logic [31:0] err;
		logic [31:0] damp;
		logic [31:0] spring;
		logic        sat;
	} step_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic signed [31:0] force_target = '0;
	logic signed [31:0] force_measured = '0;
	logic [23:0] time_step = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] delta_normal, position, velocity, acceleration;
	logic signed [31:0] integral, contact_error, damping_force, spring_force;
	logic saturated;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;

	normal_axis_admittance_step dut (.*);

	always #5 clk = ~clk;

	// Predictor state and register copies.
	longint m_mass, m_damp, m_stiff, m_leak, m_ilim, m_step, m_vlim, m_dlim;
	longint s_integ, s_vel, s_pos, s_acc, s_cmd, s_err, s_damp, s_spring;
	bit s_sat;

	step_word_t pending_words[$];
	step_result_t expected_results[$];
	int error_count = 0;
	int results_seen = 0;
	int steps_sent = 0;
	int clears_sent = 0;
	int holds_sent = 0;
	longint cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	bit in_taken = 1'b0;

	function automatic longint rnd_sh(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint clampm(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint sat_32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	task automatic clear_plant_state();
		s_integ = 0; s_vel = 0; s_pos = 0; s_acc = 0;
		s_cmd = 0; s_err = 0; s_damp = 0; s_spring = 0; s_sat = 0;
	endtask

	task automatic advance_admittance(input step_word_t w);
		longint mass, leak, ilim, slim, vlim, dlim, dt;
		longint err, integ, damp, spring, num, acc, vel, cmd, pos, delta;
		step_result_t r;
		dt = w.dt;
		if (w.op == nas_pkg::OP_CLEAR) begin
			clear_plant_state();
			delta = 0;
		end else if (dt == 0) begin
			delta = s_cmd;
		end else begin
			mass = m_mass < 3277 ? 3277 : m_mass;
			leak = m_leak > 65536 ? 65536 : m_leak;
			ilim = m_ilim < 6554 ? 6554 : m_ilim;
			slim = m_step < 2684 ? 2684 : m_step;
			vlim = m_vlim < 2684 ? 2684 : m_vlim;
			dlim = m_dlim < slim ? slim : m_dlim;
			err = sat_32(longint'($signed(w.ft)) - longint'($signed(w.fm)));
			if (absl(err) < longint'(nas_pkg::DEADBAND)) err = 0;
			integ = rnd_sh((65536 - leak) * s_integ, 16) + rnd_sh(err * dt, 24);
			integ = clampm(integ, ilim);
			damp = sat_32(rnd_sh(m_damp * s_vel, 28));
			spring = sat_32(rnd_sh(m_stiff * s_pos, 28));
			num = err + integ - damp - spring;
			acc = (num * 16777216) / mass;
			acc = clampm(acc, longint'(nas_pkg::ACC_MAX));
			vel = clampm(s_vel + rnd_sh(acc * dt, 20), vlim);
			cmd = clampm(rnd_sh(vel * dt, 24), slim);
			pos = s_pos + cmd;
			s_sat = absl(pos) >= dlim || absl(cmd) >= slim;
			pos = clampm(pos, dlim);
			s_integ = integ; s_acc = acc; s_vel = vel; s_pos = pos;
			s_cmd = cmd; s_err = err; s_damp = damp; s_spring = spring;
			delta = cmd;
		end
		r.delta = delta[31:0]; r.pos = s_pos[31:0]; r.vel = s_vel[31:0];
		r.acc = s_acc[31:0]; r.integ = s_integ[31:0]; r.err = s_err[31:0];
		r.damp = s_damp[31:0]; r.spring = s_spring[31:0]; r.sat = s_sat;
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("MISMATCH word %0d %s: got %h expected %h", results_seen, what, got, want);
	endtask

	// Driver: bursts with random gaps; a word stays until it has been taken.
	always @(negedge clk) begin
		step_word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				operation <= w.op;
				force_target <= w.ft;
				force_measured <= w.fm;
				time_step <= w.dt;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 90);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
		stall_phase = (stall_phase + 1) % 400;
		if (stall_phase < 150) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 2) == 0);
	end

	// Accepted input words feed the predictor; accepted results are checked.
	always @(posedge clk) begin
		step_result_t e;
		cycle_count <= cycle_count + 1;
		if (in_valid && !in_stall) begin
			in_taken = 1'b1;
			advance_admittance({operation, force_target, force_measured, time_step});
		end
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$display("MISMATCH unexpected result word");
			end else begin
				e = expected_results.pop_front();
				if (delta_normal !== e.delta) report_mismatch("delta_normal", delta_normal, e.delta);
				if (position !== e.pos) report_mismatch("position", position, e.pos);
				if (velocity !== e.vel) report_mismatch("velocity", velocity, e.vel);
				if (acceleration !== e.acc) report_mismatch("acceleration", acceleration, e.acc);
				if (integral !== e.integ) report_mismatch("integral", integral, e.integ);
				if (contact_error !== e.err)
					report_mismatch("contact_error", contact_error, e.err);
				if (damping_force !== e.damp)
					report_mismatch("damping_force", damping_force, e.damp);
				if (spring_force !== e.spring)
					report_mismatch("spring_force", spring_force, e.spring);
				if (saturated !== e.sat)
					report_mismatch("saturated", 32'(saturated), 32'(e.sat));
			end
			results_seen++;
		end
		if (cycle_count > 3000000) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("normal_axis_admittance_step test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input longint val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[30:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			nas_pkg::REG_MASS: m_mass = val[30:0];
			nas_pkg::REG_DAMP: m_damp = val[30:0];
			nas_pkg::REG_STIFF: m_stiff = val[30:0];
			nas_pkg::REG_LEAK: m_leak = val[16:0];
			nas_pkg::REG_ILIM: m_ilim = val[30:0];
			nas_pkg::REG_STEP: m_step = val[30:0];
			nas_pkg::REG_VLIM: m_vlim = val[30:0];
			default: m_dlim = val[30:0];
		endcase
	endtask

	task automatic queue_word(input logic op, input logic [31:0] ft, input logic [31:0] fm,
			input logic [23:0] dt);
		step_word_t w;
		w.op = op; w.ft = ft; w.fm = fm; w.dt = dt;
		pending_words.push_back(w);
		if (op == nas_pkg::OP_CLEAR) clears_sent++;
		else if (dt == 0) holds_sent++;
		else steps_sent++;
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic queue_random(input int count);
		logic [31:0] base;
		int k;
		for (k = 0; k < count; k++) begin
			base = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21);
			case ($urandom_range(0, 19))
				0: queue_word(nas_pkg::OP_CLEAR, $urandom, $urandom, 24'($urandom));
				1: queue_word(nas_pkg::OP_STEP, $urandom, $urandom, 24'd0);
				2: queue_word(nas_pkg::OP_STEP, $urandom, $urandom, 24'($urandom));
				default: queue_word(nas_pkg::OP_STEP, base,
					base + $urandom_range(0, 1 << 20) - (1 << 19),
					24'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1000, 300000)));
			endcase
		end
	endtask

	// Register settings: low and high extremes, a random setting and a fixed one.
	task automatic load_setting(input int which);
		case (which)
			0: begin
				write_reg(nas_pkg::REG_MASS, 0); write_reg(nas_pkg::REG_DAMP, 31'h7fffffff);
				write_reg(nas_pkg::REG_STIFF, 31'h7fffffff);
				write_reg(nas_pkg::REG_LEAK, 17'h1ffff);
				write_reg(nas_pkg::REG_ILIM, 0); write_reg(nas_pkg::REG_STEP, 0);
				write_reg(nas_pkg::REG_VLIM, 0); write_reg(nas_pkg::REG_DLIM, 0);
			end
			1: begin
				write_reg(nas_pkg::REG_MASS, 31'h7fffffff); write_reg(nas_pkg::REG_DAMP, 0);
				write_reg(nas_pkg::REG_STIFF, 0); write_reg(nas_pkg::REG_LEAK, 65536);
				write_reg(nas_pkg::REG_ILIM, 31'h7fffffff);
				write_reg(nas_pkg::REG_STEP, 31'h7fffffff);
				write_reg(nas_pkg::REG_VLIM, 31'h7fffffff);
				write_reg(nas_pkg::REG_DLIM, 31'h7fffffff);
			end
			2: begin
				write_reg(nas_pkg::REG_MASS, $urandom_range(3000, 400000));
				write_reg(nas_pkg::REG_DAMP, $urandom_range(0, 1 << 22));
				write_reg(nas_pkg::REG_STIFF, $urandom_range(0, 1 << 24));
				write_reg(nas_pkg::REG_LEAK, $urandom_range(0, 70000));
				write_reg(nas_pkg::REG_ILIM, $urandom_range(6000, 1 << 24));
				write_reg(nas_pkg::REG_STEP, $urandom_range(2000, 1 << 22));
				write_reg(nas_pkg::REG_VLIM, $urandom_range(2000, 1 << 26));
				write_reg(nas_pkg::REG_DLIM, $urandom_range(0, 1 << 27));
			end
			default: begin
				write_reg(nas_pkg::REG_MASS, 65536); write_reg(nas_pkg::REG_DAMP, 1 << 17);
				write_reg(nas_pkg::REG_STIFF, 1 << 20); write_reg(nas_pkg::REG_LEAK, 655);
				write_reg(nas_pkg::REG_ILIM, 655360); write_reg(nas_pkg::REG_STEP, 268435);
				write_reg(nas_pkg::REG_VLIM, 2684355); write_reg(nas_pkg::REG_DLIM, 100);
			end
		endcase
	endtask

	initial begin
		int p;
		m_mass = 65536; m_damp = 0; m_stiff = 0; m_leak = 0;
		m_ilim = 655360; m_step = 268435; m_vlim = 2684355; m_dlim = 2684355;
		clear_plant_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words under reset settings: field extremes, hold, clear.
		queue_word(nas_pkg::OP_STEP, 32'h7fffffff, 32'h80000000, 24'hffffff);
		queue_word(nas_pkg::OP_STEP, 32'h80000000, 32'h7fffffff, 24'hffffff);
		queue_word(nas_pkg::OP_STEP, 32'h00010000, 32'h0, 24'd1);
		queue_word(nas_pkg::OP_STEP, 32'hffffffff, 32'hffffffff, 24'h0);
		queue_word(nas_pkg::OP_STEP, 32'h00640000, 32'h0, 24'h010000);
		queue_word(nas_pkg::OP_STEP, 32'h00640000, 32'h0, 24'h000000);
		queue_word(nas_pkg::OP_CLEAR, 32'hffffffff, 32'h0, 24'hffffff);
		queue_word(nas_pkg::OP_STEP, 32'h0, 32'h0, 24'h0);
		queue_word(nas_pkg::OP_STEP, 32'h0, 32'h00050000, 24'h800000);
		queue_word(nas_pkg::OP_CLEAR, 32'h0, 32'hffffffff, 24'h0);
		drain();

		for (p = 0; p < 8; p++) begin
			load_setting(p % 4);
			queue_word(nas_pkg::OP_STEP, 32'h7fffffff, 32'h80000000, 24'hffffff);
			queue_word(nas_pkg::OP_STEP, 32'h80000000, 32'h7fffffff, 24'h000001);
			queue_random(170);
			drain();
		end

		$display("Ran %0d control steps, %0d holds and %0d clears; %0d result words checked.",
			steps_sent, holds_sent, clears_sent, results_seen);
		$display("Four register settings, each loaded twice after the reset settings, were used.");
		if (error_count == 0) begin
			$display("normal_axis_admittance_step test passed");
		end else begin
			$display("normal_axis_admittance_step test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/nas_pkg.sv
rtl/core/nas_mul.sv
rtl/core/nas_div.sv
rtl/core/normal_axis_admittance_step.sv
dv/normal_axis_admittance_step_tb.sv
